FILE: rtl/core/aat_pkg.sv
// Shared widths, types and register codes for the box transform pipeline.
`timescale 1ns / 1ps
package aat_pkg;

    localparam int COORD_BITS = 24;
    localparam int COEFF_BITS = 16;
    localparam int COEFF_FRAC = COEFF_BITS - 4;
    localparam int AXES       = 3;
    localparam int ROW_W      = AXES * COEFF_BITS;
    localparam int PT_W       = COORD_BITS + 1;
    localparam int PROD_W     = PT_W + COEFF_BITS;
    localparam int TERM_W     = PROD_W - COEFF_FRAC;
    localparam int SUM_W      = TERM_W + 2;
    localparam int NSTAGE     = 6;

    localparam int REG_COUNT  = 6;
    localparam int REG_IDX_W  = $clog2(REG_COUNT);
    localparam int CFG_DATA_W = 64;
    localparam int CFG_ADDR_W = REG_IDX_W + 3;

    typedef logic signed [COORD_BITS-1:0]   t_coord;
    typedef logic        [COORD_BITS-2:0]   t_size;
    typedef logic signed [COEFF_BITS-1:0]   t_coeff;
    typedef logic signed [PT_W-1:0]         t_point;
    typedef logic signed [PROD_W-1:0]       t_prod;
    typedef logic signed [TERM_W-1:0]       t_term;
    typedef logic signed [SUM_W-1:0]        t_sum;
    typedef logic        [ROW_W-1:0]        t_row;
    typedef logic        [CFG_DATA_W-1:0]   t_cfg_data;
    typedef logic        [CFG_ADDR_W-1:0]   t_cfg_addr;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_X_ROW,
        REG_Y_ROW,
        REG_Z_ROW,
        REG_X_TRANS,
        REG_Y_TRANS,
        REG_Z_TRANS
    } t_reg_idx;

    typedef struct packed {
        logic [NSTAGE-1:0] en;
    } t_pipe_ctl;

endpackage

FILE: rtl/core/aat_cfg.sv
// APB register file holding the matrix rows and the translations.
`timescale 1ns / 1ps
module aat_cfg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  aat_pkg::t_cfg_addr   paddr,
    input  aat_pkg::t_cfg_data   pwdata,
    output aat_pkg::t_cfg_data   prdata,
    output logic                 pready,
    output aat_pkg::t_coeff      o_coeff [aat_pkg::AXES][aat_pkg::AXES],
    output aat_pkg::t_coord      o_trans [aat_pkg::AXES]
);
    import aat_pkg::*;

    t_row     r_row   [AXES];
    t_coord   r_trans [AXES];
    t_row     n_row   [AXES];
    t_coord   n_trans [AXES];
    logic     w_wr;
    t_reg_idx w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign w_idx  = t_reg_idx'(paddr[CFG_ADDR_W-1:3]);

    always_comb begin
        n_row   = r_row;
        n_trans = r_trans;
        if (w_wr) begin
            case (w_idx)
                REG_X_ROW:   n_row[0]   = pwdata[ROW_W-1:0];
                REG_Y_ROW:   n_row[1]   = pwdata[ROW_W-1:0];
                REG_Z_ROW:   n_row[2]   = pwdata[ROW_W-1:0];
                REG_X_TRANS: n_trans[0] = pwdata[COORD_BITS-1:0];
                REG_Y_TRANS: n_trans[1] = pwdata[COORD_BITS-1:0];
                REG_Z_TRANS: n_trans[2] = pwdata[COORD_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < AXES; a++) begin
                r_row[a]   <= t_row'(1) << (a * COEFF_BITS + COEFF_FRAC);
                r_trans[a] <= '0;
            end
        end else begin
            r_row   <= n_row;
            r_trans <= n_trans;
        end
    end

    always_comb begin
        case (w_idx)
            REG_X_ROW:   prdata = CFG_DATA_W'(r_row[0]);
            REG_Y_ROW:   prdata = CFG_DATA_W'(r_row[1]);
            REG_Z_ROW:   prdata = CFG_DATA_W'(r_row[2]);
            REG_X_TRANS: prdata = CFG_DATA_W'(unsigned'(r_trans[0]));
            REG_Y_TRANS: prdata = CFG_DATA_W'(unsigned'(r_trans[1]));
            REG_Z_TRANS: prdata = CFG_DATA_W'(unsigned'(r_trans[2]));
            default:     prdata = '0;
        endcase
    end

    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            o_trans[a] = r_trans[a];
            for (int k = 0; k < AXES; k++) begin
                o_coeff[a][k] = r_row[a][k*COEFF_BITS +: COEFF_BITS];
            end
        end
    end

endmodule

FILE: rtl/core/aat_axis.sv
// Pipeline for one output axis: products, per-term extremes, sums, saturation, size.
`timescale 1ns / 1ps
module aat_axis (
    input  logic               i_clk,
    input  aat_pkg::t_pipe_ctl i_ctl,
    input  aat_pkg::t_coeff    i_coeff [aat_pkg::AXES],
    input  aat_pkg::t_coord    i_trans,
    input  aat_pkg::t_point    i_p0    [aat_pkg::AXES],
    input  aat_pkg::t_point    i_p1    [aat_pkg::AXES],
    output aat_pkg::t_coord    o_origin,
    output aat_pkg::t_size     o_size,
    output logic               o_clip
);
    import aat_pkg::*;

    localparam t_sum S_MAX = t_sum'({(COORD_BITS-1){1'b1}});
    localparam t_sum S_MIN = -S_MAX - t_sum'(1);

    t_prod  w_prod0 [AXES];
    t_prod  w_prod1 [AXES];
    t_term  r_t0    [AXES];
    t_term  r_t1    [AXES];
    t_term  r_lo_t  [AXES];
    t_term  r_hi_t  [AXES];
    t_sum   r_lo;
    t_sum   r_hi;
    t_coord r_mn;
    t_coord r_mx;
    logic   r_clip5;
    t_coord n_mn;
    t_coord n_mx;
    logic   n_clip5;
    logic signed [COORD_BITS:0] w_diff;
    t_size  n_size;
    logic   n_size_clip;
    t_coord r_origin;
    t_size  r_size;
    logic   r_clip;

    // Every corner mixes the two values of each input axis freely, and the
    // floor shift is monotone, so the extreme sum is the sum of per-term extremes.
    always_comb begin
        for (int k = 0; k < AXES; k++) begin
            w_prod0[k] = i_coeff[k] * i_p0[k];
            w_prod1[k] = i_coeff[k] * i_p1[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[1]) begin
            for (int k = 0; k < AXES; k++) begin
                r_t0[k] <= TERM_W'(w_prod0[k] >>> COEFF_FRAC);
                r_t1[k] <= TERM_W'(w_prod1[k] >>> COEFF_FRAC);
            end
        end
        if (i_ctl.en[2]) begin
            for (int k = 0; k < AXES; k++) begin
                r_lo_t[k] <= (r_t0[k] < r_t1[k]) ? r_t0[k] : r_t1[k];
                r_hi_t[k] <= (r_t0[k] < r_t1[k]) ? r_t1[k] : r_t0[k];
            end
        end
        if (i_ctl.en[3]) begin
            r_lo <= SUM_W'(i_trans) + SUM_W'(r_lo_t[0]) + SUM_W'(r_lo_t[1])
                    + SUM_W'(r_lo_t[2]);
            r_hi <= SUM_W'(i_trans) + SUM_W'(r_hi_t[0]) + SUM_W'(r_hi_t[1])
                    + SUM_W'(r_hi_t[2]);
        end
        if (i_ctl.en[4]) begin
            r_mn    <= n_mn;
            r_mx    <= n_mx;
            r_clip5 <= n_clip5;
        end
        if (i_ctl.en[5]) begin
            r_origin <= r_mn;
            r_size   <= n_size;
            r_clip   <= r_clip5 || n_size_clip;
        end
    end

    always_comb begin
        n_clip5 = 1'b0;
        if (r_lo < S_MIN) begin
            n_mn    = COORD_BITS'(S_MIN);
            n_clip5 = 1'b1;
        end else if (r_lo > S_MAX) begin
            n_mn    = COORD_BITS'(S_MAX);
            n_clip5 = 1'b1;
        end else begin
            n_mn = COORD_BITS'(r_lo);
        end
        if (r_hi < S_MIN) begin
            n_mx    = COORD_BITS'(S_MIN);
            n_clip5 = 1'b1;
        end else if (r_hi > S_MAX) begin
            n_mx    = COORD_BITS'(S_MAX);
            n_clip5 = 1'b1;
        end else begin
            n_mx = COORD_BITS'(r_hi);
        end
    end

    assign w_diff = {r_mx[COORD_BITS-1], r_mx} - {r_mn[COORD_BITS-1], r_mn};

    always_comb begin
        if (w_diff[COORD_BITS]) begin
            n_size      = '0;
            n_size_clip = 1'b1;
        end else if (w_diff[COORD_BITS-1]) begin
            n_size      = '1;
            n_size_clip = 1'b1;
        end else begin
            n_size      = w_diff[COORD_BITS-2:0];
            n_size_clip = 1'b0;
        end
    end

    assign o_origin = r_origin;
    assign o_size   = r_size;
    assign o_clip   = r_clip;

endmodule

FILE: rtl/core/aabb_affine_transform.sv
// Top level of the fixed-point affine transform of an axis-aligned box.
//
//  channel   direction  handshake             payload
//  input     in         i_valid / o_ready     i_in_origin_{x,y,z}, i_in_size_{x,y,z}
//  output    out        o_valid / i_ready     o_out_origin_{x,y,z}, o_out_size_{x,y,z},
//                                             o_clipped
//  config    in         psel/penable/pready   paddr, pwdata, prdata (APB, 64-bit data)
//
// A box beat is accepted every cycle while o_ready is high; each stage below is registered.
// The six stages are corner formation, products, per-term extremes, sums, clamping
// of the extremes, and the size with its clamp.
// Each stage holds its beat when the stage after it is full and stalled, so a
// stall backs up only as far as the first empty stage.
// Reset clears all stage valid bits and returns the matrix to identity.
`timescale 1ns / 1ps
module aabb_affine_transform (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  aat_pkg::t_coord      i_in_origin_x,
    input  aat_pkg::t_coord      i_in_origin_y,
    input  aat_pkg::t_coord      i_in_origin_z,
    input  aat_pkg::t_coord      i_in_size_x,
    input  aat_pkg::t_coord      i_in_size_y,
    input  aat_pkg::t_coord      i_in_size_z,
    output logic                 o_valid,
    input  logic                 i_ready,
    output aat_pkg::t_coord      o_out_origin_x,
    output aat_pkg::t_coord      o_out_origin_y,
    output aat_pkg::t_coord      o_out_origin_z,
    output aat_pkg::t_size       o_out_size_x,
    output aat_pkg::t_size       o_out_size_y,
    output aat_pkg::t_size       o_out_size_z,
    output logic                 o_clipped,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  aat_pkg::t_cfg_addr   paddr,
    input  aat_pkg::t_cfg_data   pwdata,
    output aat_pkg::t_cfg_data   prdata,
    output logic                 pready
);
    import aat_pkg::*;

    t_coeff    w_coeff [AXES][AXES];
    t_coord    w_trans [AXES];
    t_coord    w_org   [AXES];
    t_coord    w_ext   [AXES];
    t_point    r_p0    [AXES];
    t_point    r_p1    [AXES];
    logic [NSTAGE-1:0] r_v;
    t_pipe_ctl w_ctl;
    t_coord    w_origin [AXES];
    t_size     w_size   [AXES];
    logic      w_clip   [AXES];

    aat_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_coeff (w_coeff),
        .o_trans (w_trans)
    );

    always_comb begin
        w_ctl.en[NSTAGE-1] = !r_v[NSTAGE-1] || i_ready;
        for (int s = NSTAGE - 2; s >= 0; s--) begin
            w_ctl.en[s] = !r_v[s] || w_ctl.en[s+1];
        end
    end

    assign o_ready = w_ctl.en[0];
    assign o_valid = r_v[NSTAGE-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_ctl.en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int s = 1; s < NSTAGE; s++) begin
                if (w_ctl.en[s]) begin
                    r_v[s] <= r_v[s-1];
                end
            end
        end
    end

    assign w_org[0] = i_in_origin_x;
    assign w_org[1] = i_in_origin_y;
    assign w_org[2] = i_in_origin_z;
    assign w_ext[0] = i_in_size_x;
    assign w_ext[1] = i_in_size_y;
    assign w_ext[2] = i_in_size_z;

    always_ff @(posedge i_clk) begin
        if (w_ctl.en[0]) begin
            for (int k = 0; k < AXES; k++) begin
                r_p0[k] <= PT_W'(w_org[k]);
                r_p1[k] <= PT_W'(w_org[k]) + PT_W'(w_ext[k]);
            end
        end
    end

    for (genvar a = 0; a < AXES; a++) begin : g_axis
        aat_axis u_axis (
            .i_clk    (i_clk),
            .i_ctl    (w_ctl),
            .i_coeff  (w_coeff[a]),
            .i_trans  (w_trans[a]),
            .i_p0     (r_p0),
            .i_p1     (r_p1),
            .o_origin (w_origin[a]),
            .o_size   (w_size[a]),
            .o_clip   (w_clip[a])
        );
    end

    assign o_out_origin_x = w_origin[0];
    assign o_out_origin_y = w_origin[1];
    assign o_out_origin_z = w_origin[2];
    assign o_out_size_x   = w_size[0];
    assign o_out_size_y   = w_size[1];
    assign o_out_size_z   = w_size[2];
    assign o_clipped      = w_clip[0] || w_clip[1] || w_clip[2];

    a_full_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((&r_v) && !i_ready) |-> !o_ready)
        else $error("Input accepted while every stage is full and stalled.");

    a_empty_accepts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v == '0) |-> o_ready)
        else $error("Empty pipeline refuses a beat.");

    a_input_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_v[0])
        else $error("Accepted beat missing from the first stage.");

    a_last_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[NSTAGE-2] && w_ctl.en[NSTAGE-1]) |=> o_valid)
        else $error("Beat lost between the last two stages.");

endmodule
